/* rtl/squb_pkg.sv */
// shared types and constants for the spi to quad uart bridge
`default_nettype none
package squb_pkg;
   typedef enum logic [2:0] {
      PH_IDLE, PH_ARG, PH_REPLY, PH_XFER, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      AC_NONE, AC_CHECK_RX, AC_GET_RX, AC_CHECK_TX, AC_PUT_TX, AC_SET_BAUD
   } cmd_type;

   typedef enum logic [1:0] {
      OP_SPI = 2'd0, OP_CS_RELEASE = 2'd1, OP_UART_RX = 2'd2, OP_TX_READY = 2'd3
   } op_type;

   localparam logic [7:0] OPCODE_CHECK_RX = 8'h10;
   localparam logic [7:0] OPCODE_GET_RX   = 8'h20;
   localparam logic [7:0] OPCODE_CHECK_TX = 8'h30;
   localparam logic [7:0] OPCODE_PUT_TX   = 8'h40;
   localparam logic [7:0] OPCODE_SET_BAUD = 8'h80;
   localparam logic [7:0] NO_DATA         = 8'hFF;
   localparam logic [3:0] BAUD_RESET      = 4'd3;

   function automatic cmd_type decode_cmd(input logic [7:0] b);
      cmd_type c;
      unique case (b & 8'hFC)
         OPCODE_CHECK_RX: c = AC_CHECK_RX;
         OPCODE_GET_RX:   c = AC_GET_RX;
         OPCODE_CHECK_TX: c = AC_CHECK_TX;
         OPCODE_PUT_TX:   c = AC_PUT_TX;
         OPCODE_SET_BAUD: c = AC_SET_BAUD;
         default:         c = AC_NONE;
      endcase
      return c;
   endfunction
endpackage
`default_nettype wire

/* rtl/spi_to_quad_uart_bridge.sv */
// top level: spi slave command engine with per channel rx and tx queues
//
// req_ carries one event per item: op 0 an spi byte exchange (req_mosi_byte),
// op 1 chip select release, op 2 a uart byte received on req_uart_channel,
// op 3 that channel's transmitter ready for a byte. each item gives exactly
// one rsp_ item: the miso byte and the tx, baud and drop indications.
// an item is taken only when no other item is in work. the queue memory
// read is issued at the accepting edge; the update and the output register
// load happen when the item completes, which waits while the output register
// holds a result that rsp_ready has not taken. rsp_valid rises with that load.
// the next item may be taken while a result waits in the output register;
// it then holds until that result is taken, so a stalled receiver drops
// req_ready once the output register and the item in work are both full.
// queue data lives in two memories (rx and tx), one per direction, with all
// channels sharing each; the per channel head and fill counters are
// registers. reset returns the command engine to idle and empties the
// queues. queue contents are not cleared.
`default_nettype none
module spi_to_quad_uart_bridge #(
   parameter int CHANNELS       = 4,
   parameter int TX_QUEUE_DEPTH = 256,
   parameter int RX_QUEUE_DEPTH = 256,
   parameter int BAUD_CODES     = 10
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_mosi_byte,
   input  wire logic [1:0] req_uart_channel,
   input  wire logic [7:0] req_uart_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_miso_byte,
   output logic            rsp_tx_valid,
   output logic [1:0]      rsp_tx_channel,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_baud_update,
   output logic [1:0]      rsp_baud_channel,
   output logic [3:0]      rsp_baud_code_out,
   output logic            rsp_rx_dropped,
   output logic            rsp_tx_dropped
);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RXP_W = $clog2(RX_QUEUE_DEPTH);
   localparam int TXP_W = $clog2(TX_QUEUE_DEPTH);
   localparam int RXF_W = RXP_W + 1;
   localparam int TXF_W = TXP_W + 1;
   localparam int RXA_W = CH_W + RXP_W;
   localparam int TXA_W = CH_W + TXP_W;

   // engine state
   squb_pkg::phase_type phase_ff, phase_in;
   squb_pkg::cmd_type   cmd_ff, cmd_in;
   logic [CH_W-1:0]     ach_ff, ach_in;
   logic [7:0]          left_ff, left_in;
   logic [RXP_W-1:0]    rx_head_ff [CHANNELS];
   logic [RXF_W-1:0]    rx_fill_ff [CHANNELS];
   logic [TXP_W-1:0]    tx_head_ff [CHANNELS];
   logic [TXF_W-1:0]    tx_fill_ff [CHANNELS];

   // captured item, waiting for its memory read
   logic       busy_ff;
   logic [1:0] op_ff;
   logic [7:0] mosi_ff, rxb_ff;
   logic [1:0] uch_ff;

   logic       ov_ff;
   logic [7:0] o_miso_ff, o_txb_ff;
   logic       o_txv_ff, o_bu_ff, o_rxd_ff, o_txd_ff;
   logic [1:0] o_txc_ff, o_bc_ff;
   logic [3:0] o_bcode_ff;

   logic complete;
   assign complete  = busy_ff && (!ov_ff || rsp_ready);
   assign req_ready = !busy_ff;

   // heads and fills only change when an item completes, so a held item
   // re-reads the same entries
   logic [RXA_W-1:0] rx_rd_addr, rx_wr_addr;
   logic [TXA_W-1:0] tx_rd_addr, tx_wr_addr;
   logic [7:0]       rx_rd_data, tx_rd_data, tx_wr_data;
   logic             rx_we, tx_we;
   logic [CH_W-1:0]  uch;
   logic             uch_ok;

   assign uch    = uch_ff[CH_W-1:0];
   assign uch_ok = 32'(uch_ff) < CHANNELS;

   squb_ram #(.ADDR_W(RXA_W)) u_rx_ram (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wr_addr), .wr_data(rxb_ff),
      .rd_addr(rx_rd_addr), .rd_data(rx_rd_data));
   squb_ram #(.ADDR_W(TXA_W)) u_tx_ram (
      .clock(clock), .wr_en(tx_we), .wr_addr(tx_wr_addr), .wr_data(tx_wr_data),
      .rd_addr(tx_rd_addr), .rd_data(tx_rd_data));

   // tx read from the incoming item at accept, from the held item after
   logic [CH_W-1:0] req_uch;
   assign req_uch    = req_uart_channel[CH_W-1:0];
   assign tx_rd_addr = busy_ff ? {uch, tx_head_ff[uch]} : {req_uch, tx_head_ff[req_uch]};
   assign rx_rd_addr = {ach_ff, rx_head_ff[ach_ff]};

   logic [7:0] miso;
   logic       txv, bu, rxd, txd;
   logic [3:0] bcode;

   always_comb begin
      squb_pkg::cmd_type c;
      logic [RXP_W-1:0] rtail;
      logic [TXP_W-1:0] ttail;
      c = squb_pkg::decode_cmd(mosi_ff);
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      ach_in   = ach_ff;
      left_in  = left_ff;
      miso = squb_pkg::NO_DATA;
      txv = 1'b0; bu = 1'b0; rxd = 1'b0; txd = 1'b0; bcode = '0;
      rx_we = 1'b0; tx_we = 1'b0;
      rtail = rx_head_ff[uch] + rx_fill_ff[uch][RXP_W-1:0];
      ttail = tx_head_ff[ach_ff] + tx_fill_ff[ach_ff][TXP_W-1:0];
      rx_wr_addr = {uch, rtail};
      tx_wr_addr = {ach_ff, ttail};
      tx_wr_data = mosi_ff;
      unique case (op_ff)
         squb_pkg::OP_SPI: begin
            unique case (phase_ff)
               squb_pkg::PH_IDLE: begin
                  if (c == squb_pkg::AC_NONE || 32'(mosi_ff[1:0]) >= CHANNELS)
                     phase_in = squb_pkg::PH_DONE;
                  else begin
                     cmd_in = c;
                     ach_in = mosi_ff[CH_W-1:0];
                     phase_in = (c == squb_pkg::AC_CHECK_RX || c == squb_pkg::AC_CHECK_TX)
                        ? squb_pkg::PH_REPLY : squb_pkg::PH_ARG;
                  end
               end
               squb_pkg::PH_REPLY: begin
                  if (cmd_ff == squb_pkg::AC_CHECK_RX)
                     miso = (32'(rx_fill_ff[ach_ff]) > 255) ? 8'hFF
                          : 8'(rx_fill_ff[ach_ff]);
                  else
                     miso = (32'(tx_fill_ff[ach_ff]) > 255) ? 8'hFF
                          : 8'(tx_fill_ff[ach_ff]);
                  phase_in = squb_pkg::PH_DONE;
               end
               squb_pkg::PH_ARG: begin
                  if (cmd_ff == squb_pkg::AC_SET_BAUD) begin
                     if (32'(mosi_ff) < BAUD_CODES) begin
                        bu = 1'b1;
                        bcode = mosi_ff[3:0];
                     end
                     phase_in = squb_pkg::PH_DONE;
                  end else if (mosi_ff == 8'd0) phase_in = squb_pkg::PH_DONE;
                  else begin
                     left_in = mosi_ff;
                     phase_in = squb_pkg::PH_XFER;
                  end
               end
               squb_pkg::PH_XFER: begin
                  if (cmd_ff == squb_pkg::AC_GET_RX) begin
                     miso = (rx_fill_ff[ach_ff] != '0) ? rx_rd_data : 8'd0;
                  end else begin
                     if (32'(tx_fill_ff[ach_ff]) < TX_QUEUE_DEPTH) tx_we = 1'b1;
                     else txd = 1'b1;
                  end
                  left_in = left_ff - 8'd1;
                  if (left_in == 8'd0) phase_in = squb_pkg::PH_DONE;
               end
               default: phase_in = squb_pkg::PH_DONE;
            endcase
         end
         squb_pkg::OP_CS_RELEASE: begin
            phase_in = squb_pkg::PH_IDLE;
            left_in = 8'd0;
         end
         squb_pkg::OP_UART_RX: begin
            if (uch_ok) begin
               if (32'(rx_fill_ff[uch]) < RX_QUEUE_DEPTH) rx_we = 1'b1;
               else rxd = 1'b1;
            end
         end
         squb_pkg::OP_TX_READY: begin
            if (uch_ok && tx_fill_ff[uch] != '0) txv = 1'b1;
         end
         default: ;
      endcase
      if (!complete) begin
         rx_we = 1'b0; tx_we = 1'b0;
      end
   end

   logic get_pop;
   assign get_pop = op_ff == squb_pkg::OP_SPI && phase_ff == squb_pkg::PH_XFER
                 && cmd_ff == squb_pkg::AC_GET_RX && rx_fill_ff[ach_ff] != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= squb_pkg::PH_IDLE;
         cmd_ff   <= squb_pkg::AC_NONE;
         ach_ff   <= '0;
         left_ff  <= '0;
         busy_ff  <= 1'b0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            rx_head_ff[i] <= '0; rx_fill_ff[i] <= '0;
            tx_head_ff[i] <= '0; tx_fill_ff[i] <= '0;
         end
      end else begin
         if (req_valid && req_ready) busy_ff <= 1'b1;
         else if (complete) busy_ff <= 1'b0;
         if (complete) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
         if (complete) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            left_ff  <= left_in;
            ach_ff   <= ach_in;
            if (rx_we) rx_fill_ff[uch] <= rx_fill_ff[uch] + 1'b1;
            if (get_pop) begin
               rx_head_ff[ach_ff] <= rx_head_ff[ach_ff] + 1'b1;
               rx_fill_ff[ach_ff] <= rx_fill_ff[ach_ff] - 1'b1;
            end
            if (tx_we) tx_fill_ff[ach_ff] <= tx_fill_ff[ach_ff] + 1'b1;
            if (txv) begin
               tx_head_ff[uch] <= tx_head_ff[uch] + 1'b1;
               tx_fill_ff[uch] <= tx_fill_ff[uch] - 1'b1;
            end
            o_miso_ff  <= miso;
            o_txv_ff   <= txv;
            o_txc_ff   <= txv ? uch_ff : 2'd0;
            o_txb_ff   <= txv ? tx_rd_data : 8'd0;
            o_bu_ff    <= bu;
            o_bc_ff    <= bu ? 2'(ach_ff) : 2'd0;
            o_bcode_ff <= bcode;
            o_rxd_ff   <= rxd;
            o_txd_ff   <= txd;
         end
      end
   end

   // item capture; the queue reads issued now return by the next cycle
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         mosi_ff <= req_mosi_byte;
         uch_ff  <= req_uart_channel;
         rxb_ff  <= req_uart_rx_byte;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_miso_byte     = o_miso_ff;
   assign rsp_tx_valid      = o_txv_ff;
   assign rsp_tx_channel    = o_txc_ff;
   assign rsp_tx_byte       = o_txb_ff;
   assign rsp_baud_update   = o_bu_ff;
   assign rsp_baud_channel  = o_bc_ff;
   assign rsp_baud_code_out = o_bcode_ff;
   assign rsp_rx_dropped    = o_rxd_ff;
   assign rsp_tx_dropped    = o_txd_ff;
endmodule
`default_nettype wire

/* rtl/squb_ram.sv */
// byte queue storage, one write and one registered read port
`default_nettype none
module squb_ram #(
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);
   logic [7:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
